FILE: src/cctr_pkg.sv
package cctr_pkg;

    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 11;
    localparam int RANK_W     = 40;
    localparam int DIMS_W     = 3;
    localparam int MASK_W     = 4;
    localparam int IDX_W      = 3;
    localparam int FIELD_DIMS = 4;

    // Remainder pipeline: DIV_BITS dividend bits retired per stage.
    localparam int DIV_BITS    = 4;
    localparam int DIV_STAGES  = COORD_W / DIV_BITS;
    // Capture stage, DIV_STAGES remainder stages, sign fix-up stage.
    localparam int LANE_STAGES = DIV_STAGES + 2;

    typedef enum logic [IDX_W-1:0] {
        REG_NUM_DIMS      = 3'd0,
        REG_DIM_SIZE_0    = 3'd1,
        REG_DIM_SIZE_1    = 3'd2,
        REG_DIM_SIZE_2    = 3'd3,
        REG_DIM_SIZE_3    = 3'd4,
        REG_PERIODIC_MASK = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic              err;
        logic [SIZE_W-1:0] ordinal;
    } lane_res_t;

    // One restoring step: shift in one dividend bit, subtract the divisor if it fits.
    function automatic logic [SIZE_W-1:0] rem_step(
        input logic [SIZE_W-1:0] rem,
        input logic              bit_in,
        input logic [SIZE_W-1:0] size
    );
        logic [SIZE_W:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, size})
        begin
            trial = trial - {1'b0, size};
        end
        return trial[SIZE_W-1:0];
    endfunction

endpackage

FILE: src/cartesian_coords_to_rank.sv
// Cartesian coordinates to linear rank. Each accepted word carries one signed coordinate
// per dimension; the block returns the row-major rank (dimension 0 most significant,
// last dimension in use least significant) and a status bit. A periodic dimension wraps
// an out-of-range coordinate by true modulo; on a non-periodic dimension, or on a
// dimension of extent 0, an out-of-range coordinate gives status 1 and rank 0. num_dims
// of 0 gives rank 0, status 0; num_dims above the lane count saturates. The rank wraps
// modulo 2^40. Throughput is one word per cycle with no bubbles while rank_stall is low.
// Each lane reduces its coordinate with a pipelined restoring remainder unit retiring
// four bits per stage, and a Horner chain with one 40x11 multiply per stage merges the
// lanes. Every stage holds its own valid bit and fills while downstream is stalled, so
// the input stalls only when the whole pipeline and the output register are full.
// Configuration writes are always ready and must only be issued while the block is idle.
module cartesian_coords_to_rank #(
    parameter int MAX_DIMS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cctr_pkg::IDX_W-1:0]           cfg_index,
    input  logic [cctr_pkg::SIZE_W-1:0]          cfg_data,

    input  logic                                 coord_valid,
    output logic                                 coord_stall,
    input  logic signed [cctr_pkg::COORD_W-1:0]  coord_0,
    input  logic signed [cctr_pkg::COORD_W-1:0]  coord_1,
    input  logic signed [cctr_pkg::COORD_W-1:0]  coord_2,
    input  logic signed [cctr_pkg::COORD_W-1:0]  coord_3,

    output logic                                 rank_valid,
    input  logic                                 rank_stall,
    output logic [cctr_pkg::RANK_W-1:0]          rank,
    output logic                                 status
);

    localparam int COORD_W     = cctr_pkg::COORD_W;
    localparam int SIZE_W      = cctr_pkg::SIZE_W;
    localparam int RANK_W      = cctr_pkg::RANK_W;
    localparam int DIMS_W      = cctr_pkg::DIMS_W;
    localparam int MASK_W      = cctr_pkg::MASK_W;
    localparam int FIELD_DIMS  = cctr_pkg::FIELD_DIMS;
    localparam int LANE_STAGES = cctr_pkg::LANE_STAGES;
    localparam int NUM_LANES   = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;
    localparam int NUM_STAGES  = LANE_STAGES + NUM_LANES;

    // Configuration registers.
    logic [DIMS_W-1:0]  num_dims_reg;
    logic [SIZE_W-1:0]  size_reg [FIELD_DIMS];
    logic [MASK_W-1:0]  periodic_mask_reg;

    // Pipeline control: one valid bit per stage, load enables ripple back from the output.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   load;

    logic                  rank_valid_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic                  status_reg;

    logic signed [COORD_W-1:0]             coord_all [FIELD_DIMS];
    logic [DIMS_W-1:0]                     n_eff;
    logic [NUM_LANES-1:0][SIZE_W-1:0]      lane_size;
    cctr_pkg::lane_res_t [NUM_LANES-1:0]   lane_res;
    logic [RANK_W-1:0]                     merge_acc;
    logic                                  merge_err;

    assign cfg_ready = 1'b1;

    // Take a configuration word; unknown register indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg      <= DIMS_W'(1);
            periodic_mask_reg <= '0;
            for (int k = 0; k < FIELD_DIMS; k++)
            begin
                size_reg[k] <= SIZE_W'(1);
            end
        end
        else if (cfg_valid)
        begin
            case (cctr_pkg::reg_index_t'(cfg_index))
                cctr_pkg::REG_NUM_DIMS:      num_dims_reg      <= cfg_data[DIMS_W-1:0];
                cctr_pkg::REG_DIM_SIZE_0:    size_reg[0]       <= cfg_data;
                cctr_pkg::REG_DIM_SIZE_1:    size_reg[1]       <= cfg_data;
                cctr_pkg::REG_DIM_SIZE_2:    size_reg[2]       <= cfg_data;
                cctr_pkg::REG_DIM_SIZE_3:    size_reg[3]       <= cfg_data;
                cctr_pkg::REG_PERIODIC_MASK: periodic_mask_reg <= cfg_data[MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Dimensions beyond the lane count are never used.
    assign n_eff = (num_dims_reg > DIMS_W'(NUM_LANES)) ? DIMS_W'(NUM_LANES) : num_dims_reg;

    assign coord_all[0] = coord_0;
    assign coord_all[1] = coord_1;
    assign coord_all[2] = coord_2;
    assign coord_all[3] = coord_3;

    // A stage loads when it is empty or its word moves on; the output register
    // loads when it is empty or its word is taken.
    assign load[NUM_STAGES] = !rank_valid_reg || !rank_stall;
    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_load
        assign load[i] = !valid_reg[i] || load[i+1];
    end

    assign coord_stall = !load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= coord_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // One lane per dimension reduces its coordinate to an ordinal in [0, size).
    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        assign lane_size[k] = size_reg[k];

        cctr_lane u_lane (
            .clk      (clk),
            .coord    (coord_all[k]),
            .size     (size_reg[k]),
            .periodic (periodic_mask_reg[k]),
            .load     (load[LANE_STAGES-1:0]),
            .res      (lane_res[k])
        );
    end

    // Merge the ordinals into the mixed-radix rank.
    cctr_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .clk   (clk),
        .load  (load[NUM_STAGES-1:LANE_STAGES]),
        .n_eff (n_eff),
        .sizes (lane_size),
        .lanes (lane_res),
        .acc   (merge_acc),
        .err   (merge_err)
    );

    // Output register: an error forces rank 0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_valid_reg <= 1'b0;
        end
        else if (load[NUM_STAGES])
        begin
            rank_valid_reg <= valid_reg[NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[NUM_STAGES])
        begin
            rank_reg   <= merge_err ? '0 : merge_acc;
            status_reg <= merge_err;
        end
    end

    assign rank_valid = rank_valid_reg;
    assign rank       = rank_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        coord_stall |-> ((&valid_reg) && rank_valid_reg))
        else $error("input stalled while the pipeline had room");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (coord_valid && !coord_stall) |=> valid_reg[0])
        else $error("accepted word did not enter the first stage");

    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NUM_STAGES-1] && !load[NUM_STAGES]) |=> valid_reg[NUM_STAGES-1])
        else $error("blocked word dropped from the last stage");

    a_error_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rank_valid && status) |-> (rank == '0))
        else $error("error status with a nonzero rank");
`endif

endmodule

FILE: src/cctr_lane.sv
module cctr_lane (
    input  logic                                     clk,
    input  logic signed [cctr_pkg::COORD_W-1:0]      coord,
    input  logic [cctr_pkg::SIZE_W-1:0]              size,
    input  logic                                     periodic,
    input  logic [cctr_pkg::LANE_STAGES-1:0]         load,
    output cctr_pkg::lane_res_t                      res
);

    localparam int COORD_W    = cctr_pkg::COORD_W;
    localparam int SIZE_W     = cctr_pkg::SIZE_W;
    localparam int DIV_BITS   = cctr_pkg::DIV_BITS;
    localparam int DIV_STAGES = cctr_pkg::DIV_STAGES;

    logic               neg_in;
    logic [COORD_W-1:0] mag_in;
    logic               err_in;

    logic [COORD_W-1:0] mag_reg [DIV_STAGES];
    logic [SIZE_W-1:0]  rem_reg [DIV_STAGES+1];
    logic               neg_reg [DIV_STAGES+1];
    logic               err_reg [DIV_STAGES+1];

    logic [SIZE_W-1:0]  ord_reg;
    logic               err_out_reg;

    // Out of range is an error unless the dimension wraps and has a nonzero extent.
    always_comb
    begin
        neg_in = coord[COORD_W-1];
        mag_in = neg_in ? $unsigned(-coord) : $unsigned(coord);
        err_in = (neg_in || ($unsigned(coord) >= COORD_W'(size)))
                 && ((size == '0) || !periodic);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            mag_reg[0] <= mag_in;
            rem_reg[0] <= '0;
            neg_reg[0] <= neg_in;
            err_reg[0] <= err_in;
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++)
    begin : g_div
        logic [SIZE_W-1:0]  rem_next;

        always_comb
        begin
            rem_next = rem_reg[j-1];
            for (int b = 0; b < DIV_BITS; b++)
            begin
                rem_next = cctr_pkg::rem_step(rem_next, mag_reg[j-1][COORD_W-1-b], size);
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[j])
            begin
                rem_reg[j] <= rem_next;
                neg_reg[j] <= neg_reg[j-1];
                err_reg[j] <= err_reg[j-1];
            end
        end

        if (j < DIV_STAGES)
        begin : g_mag
            always_ff @(posedge clk)
            begin
                if (load[j])
                begin
                    mag_reg[j] <= mag_reg[j-1] << DIV_BITS;
                end
            end
        end
    end

    // Negative coordinate: fold the magnitude remainder back to a true modulo.
    always_ff @(posedge clk)
    begin
        if (load[DIV_STAGES+1])
        begin
            ord_reg     <= (neg_reg[DIV_STAGES] && (rem_reg[DIV_STAGES] != '0))
                           ? size - rem_reg[DIV_STAGES] : rem_reg[DIV_STAGES];
            err_out_reg <= err_reg[DIV_STAGES];
        end
    end

    assign res = '{err: err_out_reg, ordinal: ord_reg};

endmodule

FILE: src/cctr_merge.sv
module cctr_merge #(
    parameter int NUM_LANES = 4
) (
    input  logic                                              clk,
    input  logic [NUM_LANES-1:0]                              load,
    input  logic [cctr_pkg::DIMS_W-1:0]                       n_eff,
    input  logic [NUM_LANES-1:0][cctr_pkg::SIZE_W-1:0]        sizes,
    input  cctr_pkg::lane_res_t [NUM_LANES-1:0]               lanes,
    output logic [cctr_pkg::RANK_W-1:0]                       acc,
    output logic                                              err
);

    localparam int RANK_W = cctr_pkg::RANK_W;
    localparam int DIMS_W = cctr_pkg::DIMS_W;
    localparam int HOLD_N = (NUM_LANES > 1) ? NUM_LANES - 1 : 1;

    logic [RANK_W-1:0]                      acc_reg  [NUM_LANES];
    logic                                   err_reg  [NUM_LANES];
    cctr_pkg::lane_res_t [NUM_LANES-1:0]    hold_reg [HOLD_N];

    // Horner form: acc = acc * size_k + ordinal_k, most significant dimension first.
    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_stage
        logic [RANK_W-1:0]                   acc_in;
        logic                                err_in;
        cctr_pkg::lane_res_t [NUM_LANES-1:0] res_in;
        logic                                in_use;
        logic [RANK_W-1:0]                   acc_next;

        if (k == 0)
        begin : g_first
            assign acc_in = '0;
            assign err_in = 1'b0;
            assign res_in = lanes;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[k-1];
            assign err_in = err_reg[k-1];
            assign res_in = hold_reg[k-1];
        end

        always_comb
        begin
            in_use   = n_eff > DIMS_W'(k);
            acc_next = in_use
                       ? acc_in * RANK_W'(sizes[k]) + RANK_W'(res_in[k].ordinal)
                       : acc_in;
        end

        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                acc_reg[k] <= acc_next;
                err_reg[k] <= err_in || (in_use && res_in[k].err);
            end
        end

        if (k < NUM_LANES - 1)
        begin : g_hold
            always_ff @(posedge clk)
            begin
                if (load[k])
                begin
                    hold_reg[k] <= res_in;
                end
            end
        end
    end

    assign acc = acc_reg[NUM_LANES-1];
    assign err = err_reg[NUM_LANES-1];

endmodule
